/* rtl/core/sync_crc16_frame_deframer_defines.svh */
// assertion macros for the sync/crc16 frame deframer
// no dependencies; included by the top level, which provides clk and rst_n
`ifndef SYNC_CRC16_FRAME_DEFRAMER_DEFINES_SVH
`define SYNC_CRC16_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge out of reset
`define SCFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// next-cycle implication
`define SCFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define SCFD_ASSERT_NOW(label, ante, cons)
`define SCFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/scfd_pkg.sv */
// shared constants, codes and crc helper for the sync/crc16 frame deframer
// no dependencies
package scfd_pkg;

    localparam int DEF_MAX_PAYLOAD = 64;

    localparam logic [7:0]  SYNC_A   = 8'h11;
    localparam logic [7:0]  SYNC_B   = 8'h94;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // result status codes
    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_LEN  = 2'd2;

    // crc-16-ccitt over one byte, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // crc after the sync pair, starting from zero
    localparam logic [15:0] SYNC_CRC = crc_byte(crc_byte(16'h0000, SYNC_A), SYNC_B);

endpackage

/* rtl/core/sync_crc16_frame_deframer.sv */
// A byte is taken while the sequencer is idle and decoded in the next cycle; a valid
// length byte, the id and payload bytes then run through the bit-serial crc shifter,
// and ready returns once it is done; after sync and crc low bytes it returns once the
// byte is decoded. A good frame with payload is read back from the ram beat by beat,
// each beat waiting for a free output register; other ends give one status beat.
// Reset (rst_n low, async) clears the sequencer, the hunt and the output valid, not the ram.
//
// top level of the deframer: byte sequencer, bit-serial crc and payload ram
// uses scfd_pkg and sync_crc16_frame_deframer_defines.svh
`include "sync_crc16_frame_deframer_defines.svh"

module sync_crc16_frame_deframer
    import scfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // msg_id[7:0], frame_len[14:8], byte_index[20:15], payload_byte[28:21], zero[31:29]
    output logic [31:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DECODE,
        C_CRC,
        C_SINGLE,
        C_READ,
        C_EMIT
    } ctrl_t;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_ID    = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRCLO = 3'd5,
        PH_CRCHI = 3'd6
    } phase_t;

    ctrl_t       ctrl_reg, ctrl_next;
    phase_t      phase_reg, phase_next;
    logic [6:0]  byte_count_reg, byte_count_next;
    logic [6:0]  held_length_reg, held_length_next;
    logic [7:0]  held_id_reg, held_id_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [7:0]  rx_reg, rx_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [5:0]  rd_idx_reg, rd_idx_next;
    logic [1:0]  single_status_reg, single_status_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [1:0]  out_user_reg, out_user_next;
    logic        out_last_reg, out_last_next;

    logic [7:0]  payload_mem [MAX_PAYLOAD];
    logic [7:0]  rd_data_reg;
    logic        mem_we;
    logic        mem_re;

    logic        out_free;
    logic        crc_fb;
    logic [6:0]  count_plus1;
    logic [6:0]  idx_plus1;
    logic [7:0]  single_id;

    assign s_axis_tready = (ctrl_reg == C_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    assign out_free    = !out_valid_reg || m_axis_tready;
    assign crc_fb      = crc_reg[15] ^ shift_reg[7];
    assign count_plus1 = byte_count_reg + 7'd1;
    assign idx_plus1   = {1'b0, rd_idx_reg} + 7'd1;
    assign single_id   = (single_status_reg == ST_GOOD) ? held_id_reg : 8'h00;

    // sequencer next state
    always_comb
    begin
        ctrl_next          = ctrl_reg;
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        held_length_next   = held_length_reg;
        held_id_next       = held_id_reg;
        crc_next           = crc_reg;
        crc_low_next       = crc_low_reg;
        rx_next            = rx_reg;
        shift_next         = shift_reg;
        bit_cnt_next       = bit_cnt_reg;
        rd_idx_next        = rd_idx_reg;
        single_status_next = single_status_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        out_user_next      = out_user_reg;
        out_last_next      = out_last_reg;
        mem_we             = 1'b0;
        mem_re             = 1'b0;

        // beat taken downstream
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (ctrl_reg)
            C_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    rx_next   = s_axis_tdata;
                    ctrl_next = C_DECODE;
                end
            end
            C_DECODE:
            begin
                ctrl_next = C_IDLE;
                case (phase_reg)
                    PH_SYNC2:
                    begin
                        if (rx_reg == SYNC_B)
                        begin
                            crc_next   = SYNC_CRC;
                            phase_next = PH_LEN;
                        end
                        else if (rx_reg != SYNC_A)
                            phase_next = PH_HUNT;
                    end
                    PH_LEN:
                    begin
                        if (rx_reg > 8'(MAX_PAYLOAD))
                        begin
                            phase_next         = PH_HUNT;
                            single_status_next = ST_LEN;
                            ctrl_next          = C_SINGLE;
                        end
                        else
                        begin
                            held_length_next = rx_reg[6:0];
                            phase_next       = PH_ID;
                            shift_next       = rx_reg;
                            bit_cnt_next     = 3'd0;
                            ctrl_next        = C_CRC;
                        end
                    end
                    PH_ID:
                    begin
                        held_id_next    = rx_reg;
                        byte_count_next = 7'd0;
                        phase_next      = (held_length_reg == 7'd0) ? PH_CRCLO : PH_DATA;
                        shift_next      = rx_reg;
                        bit_cnt_next    = 3'd0;
                        ctrl_next       = C_CRC;
                    end
                    PH_DATA:
                    begin
                        mem_we          = 1'b1;
                        byte_count_next = count_plus1;
                        if (count_plus1 >= held_length_reg)
                            phase_next = PH_CRCLO;
                        shift_next   = rx_reg;
                        bit_cnt_next = 3'd0;
                        ctrl_next    = C_CRC;
                    end
                    PH_CRCLO:
                    begin
                        crc_low_next = rx_reg;
                        phase_next   = PH_CRCHI;
                    end
                    PH_CRCHI:
                    begin
                        phase_next = PH_HUNT;
                        if (crc_low_reg != crc_reg[7:0] || rx_reg != crc_reg[15:8])
                        begin
                            single_status_next = ST_CRC;
                            ctrl_next          = C_SINGLE;
                        end
                        else if (held_length_reg == 7'd0)
                        begin
                            single_status_next = ST_GOOD;
                            ctrl_next          = C_SINGLE;
                        end
                        else
                        begin
                            rd_idx_next = 6'd0;
                            ctrl_next   = C_READ;
                        end
                    end
                    default:
                    begin
                        phase_next = (rx_reg == SYNC_A) ? PH_SYNC2 : PH_HUNT;
                    end
                endcase
            end
            C_CRC:
            begin
                // one crc bit per cycle, msb first
                crc_next     = {crc_reg[14:0], 1'b0} ^ (crc_fb ? CRC_POLY : 16'h0000);
                shift_next   = {shift_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                    ctrl_next = C_IDLE;
            end
            C_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, 8'h00, 6'd0, 7'd0, single_id};
                    out_user_next  = single_status_reg;
                    out_last_next  = 1'b1;
                    ctrl_next      = C_IDLE;
                end
            end
            C_READ:
            begin
                mem_re    = 1'b1;
                ctrl_next = C_EMIT;
            end
            C_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, rd_data_reg, rd_idx_reg, held_length_reg,
                                      held_id_reg};
                    out_user_next  = ST_GOOD;
                    out_last_next  = (idx_plus1 == held_length_reg);
                    if (idx_plus1 == held_length_reg)
                        ctrl_next = C_IDLE;
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 6'd1;
                        ctrl_next   = C_READ;
                    end
                end
            end
            default:
            begin
                ctrl_next = C_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg          <= C_IDLE;
            phase_reg         <= PH_HUNT;
            byte_count_reg    <= 7'd0;
            held_length_reg   <= 7'd0;
            held_id_reg       <= 8'h00;
            crc_reg           <= 16'h0000;
            crc_low_reg       <= 8'h00;
            bit_cnt_reg       <= 3'd0;
            rd_idx_reg        <= 6'd0;
            single_status_reg <= ST_GOOD;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            ctrl_reg          <= ctrl_next;
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            held_length_reg   <= held_length_next;
            held_id_reg       <= held_id_next;
            crc_reg           <= crc_next;
            crc_low_reg       <= crc_low_next;
            bit_cnt_reg       <= bit_cnt_next;
            rd_idx_reg        <= rd_idx_next;
            single_status_reg <= single_status_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        rx_reg       <= rx_next;
        shift_reg    <= shift_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    // payload ram, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            payload_mem[byte_count_reg[AW-1:0]] <= rx_reg;
        if (mem_re)
            rd_data_reg <= payload_mem[rd_idx_reg[AW-1:0]];
    end

    // checks
    `SCFD_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SCFD_ASSERT_NOW(a_error_beat_form, m_axis_tvalid && (m_axis_tuser != ST_GOOD),
                     m_axis_tlast && (m_axis_tdata == 32'h0))
    `SCFD_ASSERT_NOW(a_index_in_range, m_axis_tvalid && (m_axis_tuser == ST_GOOD) && !m_axis_tlast,
                     ({1'b0, m_axis_tdata[20:15]} + 7'd1) < m_axis_tdata[14:8])

endmodule

/* dv/testbench.sv */
// self-checking testbench for the sync/crc16 frame deframer: framed byte streams in,
// predicted payload and status beats compared field by field at the output
// depends on scfd_pkg and the sync_crc16_frame_deframer top level
`timescale 1ns / 100ps

module testbench
    import scfd_pkg::*;
();

    localparam int HOLD_CYCLES  = 1500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [2:0]
    {
        FP_HUNT,
        FP_SYNC2,
        FP_LEN,
        FP_ID,
        FP_DATA,
        FP_CRC_LO,
        FP_CRC_HI
    } frame_phase_t;

    typedef struct
    {
        logic [7:0] msg_id;
        logic [6:0] frame_len;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       last;
    } deframed_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte[7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // msg_id[7:0], frame_len[14:8], byte_index[20:15], payload_byte[28:21], zero[31:29]
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;           // status[1:0]
    logic        m_axis_tlast;

    // bytes waiting to be sent and beats waiting to come out
    logic [7:0]     pending_bytes[$];
    deframed_beat_t expected_beats[$];

    int send_idle_pct = 26;
    int recv_idle_pct = 78;
    int stim_count    = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;

    // predicted deframer state
    frame_phase_t fp_phase = FP_HUNT;
    logic [6:0]   fp_count = '0;
    logic [6:0]   fp_len   = '0;
    logic [7:0]   fp_id    = '0;
    logic [15:0]  fp_crc   = '0;
    logic [7:0]   fp_crc_lo = '0;
    logic [7:0]   fp_store[64];

    sync_crc16_frame_deframer uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // crc-16-ccitt, one input bit at a time through the feedback tap
    function automatic logic [15:0] crc_ccitt(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic deframed_beat_t status_beat(input logic [1:0] st);
        deframed_beat_t r;
        r.msg_id       = '0;
        r.frame_len    = '0;
        r.byte_index   = '0;
        r.payload_byte = '0;
        r.status       = st;
        r.last         = 1'b1;
        return r;
    endfunction

    // advance the predicted deframer by one received byte, queue the beats it causes
    task automatic deframe_byte(input logic [7:0] b);
        deframed_beat_t r;
        case (fp_phase)
            FP_SYNC2:
            begin
                if (b == SYNC_B)
                begin
                    fp_crc   = crc_ccitt(crc_ccitt(16'h0000, SYNC_A), b);
                    fp_phase = FP_LEN;
                end
                else if (b != SYNC_A)
                    fp_phase = FP_HUNT;
            end
            FP_LEN:
            begin
                if (b > DEF_MAX_PAYLOAD)
                begin
                    fp_phase = FP_HUNT;
                    expected_beats.insert(expected_beats.size(), status_beat(ST_LEN));
                end
                else
                begin
                    fp_len   = b[6:0];
                    fp_crc   = crc_ccitt(fp_crc, b);
                    fp_phase = FP_ID;
                end
            end
            FP_ID:
            begin
                fp_id    = b;
                fp_crc   = crc_ccitt(fp_crc, b);
                fp_count = '0;
                fp_phase = (fp_len == 0) ? FP_CRC_LO : FP_DATA;
            end
            FP_DATA:
            begin
                fp_store[fp_count[5:0]] = b;
                fp_crc   = crc_ccitt(fp_crc, b);
                fp_count = fp_count + 7'd1;
                if (fp_count >= fp_len)
                    fp_phase = FP_CRC_LO;
            end
            FP_CRC_LO:
            begin
                fp_crc_lo = b;
                fp_phase  = FP_CRC_HI;
            end
            FP_CRC_HI:
            begin
                fp_phase = FP_HUNT;
                if (fp_crc_lo != fp_crc[7:0] || b != fp_crc[15:8])
                    expected_beats.insert(expected_beats.size(), status_beat(ST_CRC));
                else if (fp_len == 0)
                begin
                    r        = status_beat(ST_GOOD);
                    r.msg_id = fp_id;
                    expected_beats.insert(expected_beats.size(), r);
                end
                else
                begin
                    for (int i = 0; i < fp_len; i++)
                    begin
                        r.msg_id       = fp_id;
                        r.frame_len    = fp_len;
                        r.byte_index   = i[5:0];
                        r.payload_byte = fp_store[i];
                        r.status       = ST_GOOD;
                        r.last         = (i + 1 == fp_len);
                        expected_beats.insert(expected_beats.size(), r);
                    end
                end
            end
            default:
                fp_phase = (b == SYNC_A) ? FP_SYNC2 : FP_HUNT;
        endcase
    endtask

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, expv, actv);
            mismatches++;
        end
    endtask

    // driver: offer pending bytes, predict on each accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                deframe_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_bytes[0];
                    pending_bytes.delete(0);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor: random ready, compare each beat with the oldest prediction
    always @(posedge clk)
    begin
        deframed_beat_t e;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat: tdata 0x%0h tuser %0d tlast %0d",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    e = expected_beats[0];
                    expected_beats.delete(0);
                    check_field("msg_id", e.msg_id, m_axis_tdata[7:0]);
                    check_field("frame_len", e.frame_len, m_axis_tdata[14:8]);
                    check_field("byte_index", e.byte_index, m_axis_tdata[20:15]);
                    check_field("payload_byte", e.payload_byte, m_axis_tdata[28:21]);
                    check_field("status", e.status, m_axis_tuser);
                    check_field("last", e.last, m_axis_tlast);
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        pending_bytes.insert(pending_bytes.size(), b);
        stim_count++;
    endtask

    // line noise, with a stray sync byte now and then
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_byte(($urandom_range(3) == 0) ? SYNC_A : 8'($urandom_range(255)));
    endtask

    // one frame, optionally with a bad crc, cut off after the given number of bytes
    task automatic send_frame(input int len, input logic [7:0] id, input bit corrupt,
                              input int cut);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        fb.insert(fb.size(), SYNC_A);
        fb.insert(fb.size(), SYNC_B);
        fb.insert(fb.size(), len[7:0]);
        fb.insert(fb.size(), id);
        for (int i = 0; i < len; i++)
            fb.insert(fb.size(), 8'($urandom_range(255)));
        crc = 16'h0000;
        foreach (fb[i])
            crc = crc_ccitt(crc, fb[i]);
        if (corrupt)
            crc = crc ^ (16'h0001 << $urandom_range(15));
        fb.insert(fb.size(), crc[7:0]);
        fb.insert(fb.size(), crc[15:8]);
        for (int i = 0; i < fb.size() && i < cut; i++)
            send_byte(fb[i]);
    endtask

    // mostly well-formed frames with small payloads, some bad, cut or oversize, and bursts of noise
    task automatic send_random_frames(input int target);
        int start;
        int r;
        int len;
        start = stim_count;
        while (stim_count - start < target)
        begin
            r   = $urandom_range(99);
            len = ($urandom_range(99) < 4) ? $urandom_range(60, DEF_MAX_PAYLOAD)
                                           : $urandom_range(0, 6);
            if (r < 62)
                send_frame(len, 8'($urandom_range(255)), 1'b0, 1000);
            else if (r < 72)
                send_frame(len, 8'($urandom_range(255)), 1'b1, 1000);
            else if (r < 78)
                send_frame($urandom_range(DEF_MAX_PAYLOAD + 1, 255), 8'h00, 1'b0, 3);
            else if (r < 88)
                send_frame(len, 8'($urandom_range(255)), 1'b0, $urandom_range(1, len + 5));
            else
                send_noise($urandom_range(1, 3));
        end
    endtask

    task automatic wait_sent();
        while (pending_bytes.size() != 0 || s_axis_tvalid)
            @(negedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: byte extremes, repeated sync, broken sync, empty payload,
        // oversize lengths, crc mismatch
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_A);
        send_frame(0, 8'hFF, 1'b0, 1000);
        send_byte(SYNC_A);
        send_byte(8'h22);
        send_frame(DEF_MAX_PAYLOAD + 1, 8'h00, 1'b0, 3);
        send_frame(255, 8'h00, 1'b0, 3);
        send_frame(1, 8'h00, 1'b1, 1000);

        // sender mostly busy, receiver mostly stalled
        send_random_frames(110);
        wait_sent();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 78;
        recv_idle_pct = 26;
        send_random_frames(110);
        wait_sent();

        // no idling; receiver holds off while frames keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
        for (int i = 0; i < 8; i++)
            send_frame(3, 8'($urandom_range(255)), 1'b0, 1000);
        send_frame(DEF_MAX_PAYLOAD, 8'($urandom_range(255)), 1'b0, 1000);
        send_random_frames(80);
        wait_sent();

        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_beats.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/scfd_pkg.sv
rtl/core/sync_crc16_frame_deframer.sv
dv/testbench.sv
